// ----- hdl/cht_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and codes of the chained hash table engine
package cht_pkg;

	localparam int NUM_BINS    = 12;
	localparam int BIN_DEPTH   = 8;
	localparam int VALUE_WIDTH = 32;

	localparam int CODE_W  = 32;
	localparam int DATA_W  = 32;
	localparam int LIVE_W  = 7;
	localparam int VAL_W   = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
	localparam int SLOTS   = NUM_BINS * BIN_DEPTH;
	localparam int BIN_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int SLOT_W  = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ENTRY_W = CODE_W + VAL_W;
	localparam int ROW_W   = BIN_DEPTH * ENTRY_W;

	// floor((2^32 - 1) / NUM_BINS), quotient estimate is at most one short
	localparam logic [CODE_W-1:0] MOD_RECIP = CODE_W'(64'(32'hFFFF_FFFF) / NUM_BINS);
	localparam logic [CODE_W-1:0] BINS_C    = CODE_W'(NUM_BINS);

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_DEL   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CODE_W-1:0] lookup_code;
		logic [DATA_W-1:0] entry_value_in;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] value_out;
		logic [LIVE_W-1:0] live_count;
	} rsp_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [VAL_W-1:0]  value;
	} slot_t;

	typedef slot_t [BIN_DEPTH-1:0] row_t;

	typedef struct packed {
		logic load;
		logic hash;
		logic bin;
		logic rd;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/cht_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/cht_ctrl.sv -----
`timescale 1ns / 1ps
// request sequencer of the hash table engine
module cht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cht_pkg::stat_t stat,
	output cht_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_BIN  = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				state_d  = S_BIN;
			end
			S_BIN: begin
				cmd.bin = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/cht_dp.sv -----
`timescale 1ns / 1ps
// datapath of the hash table engine: bin reduction, bin row memory, slot compare, result beat
module cht_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  cht_pkg::req_t  req,
	input  cht_pkg::cmd_t  cmd,
	output cht_pkg::stat_t stat,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cht_pkg::rsp_t  rsp
);

	cht_pkg::req_t                      req_q;
	logic [2*cht_pkg::CODE_W-1:0]       prod_q;
	logic [cht_pkg::BIN_W-1:0]          bin_q;
	logic [cht_pkg::BIN_DEPTH-1:0]      valid_q [cht_pkg::NUM_BINS];
	logic [cht_pkg::CNT_W-1:0]          count_q;
	cht_pkg::rsp_t                      rsp_q;
	logic                               rsp_valid_q;

	logic [cht_pkg::CODE_W-1:0]         qn;
	logic [cht_pkg::CODE_W-1:0]         rem;
	logic [cht_pkg::CODE_W-1:0]         rem_fix;

	logic [cht_pkg::ROW_W-1:0]          rd_data;
	cht_pkg::row_t                      row;
	cht_pkg::row_t                      new_row;
	logic [cht_pkg::BIN_DEPTH-1:0]      vrow;
	logic [cht_pkg::BIN_DEPTH-1:0]      new_vrow;
	logic                               hit_found;
	logic                               free_found;
	logic [cht_pkg::SLOT_W-1:0]         hit_idx;
	logic [cht_pkg::SLOT_W-1:0]         free_idx;
	logic [cht_pkg::SLOT_W-1:0]         slot_sel;
	logic                               row_wr;
	logic                               clear_all;
	logic [cht_pkg::CNT_W-1:0]          count_d;
	cht_pkg::rsp_t                      rsp_d;

	// code mod NUM_BINS by reciprocal estimate and one correction
	assign qn      = prod_q[2*cht_pkg::CODE_W-1:cht_pkg::CODE_W] * cht_pkg::BINS_C;
	assign rem     = req_q.lookup_code - qn;
	assign rem_fix = (rem >= cht_pkg::BINS_C) ? (rem - cht_pkg::BINS_C) : rem;

	assign row  = cht_pkg::row_t'(rd_data);
	assign vrow = valid_q[bin_q];

	always_comb begin
		hit_found  = 1'b0;
		free_found = 1'b0;
		hit_idx    = '0;
		free_idx   = '0;
		for (int i = 0; i < cht_pkg::BIN_DEPTH; i++) begin
			if (!hit_found && vrow[i] && (row[i].code == req_q.lookup_code)) begin
				hit_found = 1'b1;
				hit_idx   = cht_pkg::SLOT_W'(i);
			end
			if (!free_found && !vrow[i]) begin
				free_found = 1'b1;
				free_idx   = cht_pkg::SLOT_W'(i);
			end
		end
	end

	assign slot_sel = hit_found ? hit_idx : free_idx;

	always_comb begin
		new_row          = row;
		new_vrow         = vrow;
		row_wr           = 1'b0;
		clear_all        = 1'b0;
		count_d          = count_q;
		rsp_d.status     = cht_pkg::ST_OK;
		rsp_d.value_out  = '0;
		case (req_q.opcode)
			cht_pkg::OP_PUT: begin
				if (hit_found || free_found) begin
					row_wr                 = 1'b1;
					new_row[slot_sel].code  = req_q.lookup_code;
					new_row[slot_sel].value = req_q.entry_value_in[cht_pkg::VAL_W-1:0];
					new_vrow[slot_sel]     = 1'b1;
					if (!hit_found) begin
						count_d = count_q + 1'b1;
					end
				end else begin
					rsp_d.status = cht_pkg::ST_FULL;
				end
			end
			cht_pkg::OP_GET, cht_pkg::OP_DEL: begin
				if (hit_found) begin
					rsp_d.value_out = cht_pkg::DATA_W'(row[hit_idx].value);
					if (req_q.opcode == cht_pkg::OP_DEL) begin
						new_vrow[hit_idx] = 1'b0;
						count_d           = count_q - 1'b1;
					end
				end else begin
					rsp_d.status = cht_pkg::ST_MISS;
				end
			end
			cht_pkg::OP_CLEAR: begin
				clear_all = 1'b1;
				count_d   = '0;
			end
			default: begin
				rsp_d.status = cht_pkg::ST_OK;
			end
		endcase
		rsp_d.live_count = cht_pkg::LIVE_W'(count_d);
	end

	cht_ram #(
		.WIDTH(cht_pkg::ROW_W),
		.DEPTH(cht_pkg::NUM_BINS)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (cmd.exec && row_wr),
		.wr_addr (bin_q),
		.wr_data (new_row),
		.rd_en   (cmd.rd),
		.rd_addr (bin_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.hash) begin
			prod_q <= (2*cht_pkg::CODE_W)'(req_q.lookup_code)
				* (2*cht_pkg::CODE_W)'(cht_pkg::MOD_RECIP);
		end
		if (cmd.bin) begin
			bin_q <= rem_fix[cht_pkg::BIN_W-1:0];
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < cht_pkg::NUM_BINS; b++) begin
				valid_q[b] <= '0;
			end
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q <= count_d;
				if (clear_all) begin
					for (int b = 0; b < cht_pkg::NUM_BINS; b++) begin
						valid_q[b] <= '0;
					end
				end else begin
					valid_q[bin_q] <= new_vrow;
				end
			end
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

// ----- hdl/chained_hash_table_engine_core.sv -----
`timescale 1ns / 1ps
// top level of the chained hash table engine
// a request beat passes through the sequencer states hash, bin, read and exec before its result beat
// (hash multiply, bin reduction, registered bin row read, compare and write-back)
// one request at a time: req_stall holds new request beats until the single sequencer is idle again
// a stalled pending result beat holds the write-back, and so also blocks a new request beat
// reset: arst_n clears valid bits, live count and control at once; no clearing pass
module chained_hash_table_engine_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cht_pkg::req_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cht_pkg::rsp_t  rsp
);

	cht_pkg::cmd_t  cmd;
	cht_pkg::stat_t stat;

	cht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the hash table engine: queued requests, shadow table, result checks
module tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int POOL_SIZE  = 156;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 120;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	cht_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cht_pkg::rsp_t rsp;

	chained_hash_table_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// shadow copy of the table
	logic                       tbl_valid [cht_pkg::SLOTS];
	logic [cht_pkg::CODE_W-1:0] tbl_code  [cht_pkg::SLOTS];
	logic [cht_pkg::VAL_W-1:0]  tbl_value [cht_pkg::SLOTS];
	int unsigned                tbl_count;

	cht_pkg::req_t pending_requests[$];
	cht_pkg::rsp_t predicted_results[$];

	int req_gap    = 0;
	int rsp_hold   = 0;
	int reqs_sent  = 0;
	int rsps_seen  = 0;
	int error_count = 0;
	int n_put = 0, n_get = 0, n_del = 0, n_clear = 0, n_miss = 0, n_full = 0;
	int unsigned peak_count = 0;

	function automatic int idle_draw(int n, int window);
		if ((n / window) % 4 == 3)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	function automatic cht_pkg::rsp_t hash_table_step(cht_pkg::req_t r);
		cht_pkg::rsp_t res;
		int   base;
		int   hit;
		res  = '0;
		res.status = cht_pkg::ST_OK;
		base = int'(r.lookup_code % cht_pkg::CODE_W'(cht_pkg::NUM_BINS)) * cht_pkg::BIN_DEPTH;
		hit  = -1;
		case (r.opcode)
		cht_pkg::OP_CLEAR: begin
			foreach (tbl_valid[i])
				tbl_valid[i] = 1'b0;
			tbl_count = 0;
			n_clear++;
		end
		default: begin
			for (int i = 0; i < cht_pkg::BIN_DEPTH; i++) begin
				if (hit < 0 && tbl_valid[base + i] && tbl_code[base + i] == r.lookup_code)
					hit = base + i;
			end
			if (r.opcode == cht_pkg::OP_PUT) begin
				n_put++;
				if (hit >= 0) begin
					tbl_value[hit] = r.entry_value_in[cht_pkg::VAL_W-1:0];
				end else begin
					res.status = cht_pkg::ST_FULL;
					for (int i = 0; i < cht_pkg::BIN_DEPTH; i++) begin
						if (res.status == cht_pkg::ST_FULL && !tbl_valid[base + i]) begin
							tbl_valid[base + i] = 1'b1;
							tbl_code[base + i]  = r.lookup_code;
							tbl_value[base + i] = r.entry_value_in[cht_pkg::VAL_W-1:0];
							tbl_count++;
							res.status = cht_pkg::ST_OK;
						end
					end
					if (res.status == cht_pkg::ST_FULL)
						n_full++;
				end
			end else begin
				if (r.opcode == cht_pkg::OP_GET)
					n_get++;
				else
					n_del++;
				if (hit < 0) begin
					res.status = cht_pkg::ST_MISS;
					n_miss++;
				end else begin
					res.value_out = cht_pkg::DATA_W'(tbl_value[hit]);
					if (r.opcode == cht_pkg::OP_DEL) begin
						tbl_valid[hit] = 1'b0;
						tbl_count--;
					end
				end
			end
		end
		endcase
		if (tbl_count > peak_count)
			peak_count = tbl_count;
		res.live_count = cht_pkg::LIVE_W'(tbl_count);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (error_count < 20)
			$display("mismatch on %s at result %0d: got %0h, expected %0h",
				what, rsps_seen, got, want);
		error_count++;
	endtask

	task automatic queue_request(logic [1:0] op, logic [cht_pkg::CODE_W-1:0] code,
		logic [cht_pkg::DATA_W-1:0] value);
		cht_pkg::req_t r;
		r.opcode         = op;
		r.lookup_code    = code;
		r.entry_value_in = value;
		pending_requests.push_back(r);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predicted_results.push_back(hash_table_step(req));
				reqs_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					req       <= pending_requests.pop_front();
					req_valid <= 1'b1;
					req_gap   = idle_draw(reqs_sent, 97);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		cht_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("beat with nothing pending", rsp.value_out, '0);
				end else begin
					want = predicted_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.value_out !== want.value_out)
						report_mismatch("value_out", rsp.value_out, want.value_out);
					if (rsp.live_count !== want.live_count)
						report_mismatch("live_count", 32'(rsp.live_count),
							32'(want.live_count));
				end
				rsp_hold = idle_draw(rsps_seen, 89);
				rsps_seen++;
			end
			if (rsp_hold > 0) begin
				rsp_stall <= 1'b1;
				rsp_hold--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog on handshake activity
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [cht_pkg::CODE_W-1:0] code_pool [POOL_SIZE];
		logic [1:0]                 op;
		logic [cht_pkg::CODE_W-1:0] code;
		logic [cht_pkg::DATA_W-1:0] value;
		int                         roll;
		int                         mode;
		int                         fill_idx;
		int                         put_pct;
		int                         get_pct;
		int                         noise_pct;

		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;
		tbl_count = 0;
		fill_idx  = 0;

		// directed: empty table, zero value, overwrite, extremes
		queue_request(cht_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
		queue_request(cht_pkg::OP_DEL, 32'hFFFF_FFFF, 32'h0);
		queue_request(cht_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_request(cht_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(cht_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(cht_pkg::OP_GET, 32'h0000_0000, 32'h0);
		queue_request(cht_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		// fill one bin, then one more is refused
		for (int k = 0; k < cht_pkg::BIN_DEPTH + 1; k++)
			queue_request(cht_pkg::OP_PUT, cht_pkg::CODE_W'(5 + cht_pkg::NUM_BINS * k),
				cht_pkg::DATA_W'(32'h100 + k));
		// free a middle slot, refill goes to the lowest free one
		queue_request(cht_pkg::OP_DEL, cht_pkg::CODE_W'(5 + cht_pkg::NUM_BINS), 32'h0);
		queue_request(cht_pkg::OP_PUT, cht_pkg::CODE_W'(5 + cht_pkg::NUM_BINS * 9),
			32'h8000_0001);
		queue_request(cht_pkg::OP_GET, cht_pkg::CODE_W'(5 + cht_pkg::NUM_BINS * 9), 32'h0);
		queue_request(cht_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		queue_request(cht_pkg::OP_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
		queue_request(cht_pkg::OP_GET, 32'h0000_0005, 32'h0);

		// random phases: fill, mixed, drain, noisy mixed
		for (int ph = 0; ph < PHASES; ph++) begin
			mode = ph % 4;
			if (mode == 0) begin
				foreach (code_pool[i])
					code_pool[i] = cht_pkg::CODE_W'($urandom_range(0, 32'h1555_5554))
						* cht_pkg::NUM_BINS + cht_pkg::CODE_W'(i % cht_pkg::NUM_BINS);
			end
			case (mode)
			0: begin put_pct = 90; get_pct = 7;  noise_pct = 5;  end
			1: begin put_pct = 40; get_pct = 35; noise_pct = 15; end
			2: begin put_pct = 15; get_pct = 35; noise_pct = 10; end
			default: begin put_pct = 35; get_pct = 35; noise_pct = 50; end
			endcase
			for (int n = 0; n < PHASE_LEN; n++) begin
				roll = $urandom_range(0, 99);
				if (mode != 0 && $urandom_range(0, 149) == 0)
					op = cht_pkg::OP_CLEAR;
				else if (roll < put_pct)
					op = cht_pkg::OP_PUT;
				else if (roll < put_pct + get_pct)
					op = cht_pkg::OP_GET;
				else
					op = cht_pkg::OP_DEL;
				if ($urandom_range(0, 99) < noise_pct) begin
					code = $urandom;
				end else if (mode == 0 && op == cht_pkg::OP_PUT) begin
					code = code_pool[fill_idx % POOL_SIZE];
					fill_idx++;
				end else begin
					code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
				end
				roll = $urandom_range(0, 99);
				if (roll < 5)
					value = '0;
				else if (roll < 10)
					value = '1;
				else
					value = $urandom;
				queue_request(op, code, value);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d requests: %0d put, %0d get, %0d delete, %0d clear",
			reqs_sent, n_put, n_get, n_del, n_clear);
		$display("%0d lookups missed, %0d puts refused on a full bin, peak live count %0d",
			n_miss, n_full, peak_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
